@@ design/line_rasterizer_clipped_core_macros.svh @@
// assertion macros shared by the rasterizer modules
// no dependencies; included by the modules that check their own logic
`ifndef LINE_RASTERIZER_CLIPPED_CORE_MACROS_SVH
`define LINE_RASTERIZER_CLIPPED_CORE_MACROS_SVH

// expression holds at every clock edge out of reset
`define LRC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("lrc assertion failed");

// consequent holds in the same cycle as the antecedent
`define LRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrc assertion failed");

// consequent holds in the cycle after the antecedent
`define LRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrc assertion failed");

`endif

@@ design/lrc_pkg.sv @@
// shared types and constants of the clipped line rasterizer
// no dependencies; imported by every rasterizer module
package lrc_pkg;

	localparam int DIM_BITS        = 13;
	localparam int STRIDE_BITS     = 15;
	localparam int COLOR_BITS      = 24;
	localparam int ADDR_BITS       = 26;
	localparam int PROD_BITS       = DIM_BITS + STRIDE_BITS;
	localparam int BYTES_PER_PIXEL = 4;
	localparam int BPP_SHIFT       = $clog2(BYTES_PER_PIXEL);

	localparam logic [DIM_BITS-1:0]    WIDTH_RESET  = 13'd1024;
	localparam logic [DIM_BITS-1:0]    HEIGHT_RESET = 13'd768;
	localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 15'd4096;
	localparam logic [COLOR_BITS-1:0]  COLOR_RESET  = 24'hFFFFFF;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} lrc_req_t;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_ROW_STRIDE   = 2'd2,
		REG_DRAW_COLOR   = 2'd3
	} lrc_reg_t;

	// classification of one queued command
	typedef struct packed {
		logic is_step;
		logic x_neg;
		logic y_neg;
		logic major_is_x;
	} lrc_ctl_t;

	typedef struct packed {
		logic [DIM_BITS-1:0]    width;
		logic [DIM_BITS-1:0]    height;
		logic [STRIDE_BITS-1:0] stride;
		logic [COLOR_BITS-1:0]  color;
	} lrc_cfg_t;

endpackage

@@ design/lrc_front.sv @@
// front end: accepts requests, works out line deltas and axis classification
// depends on lrc_pkg; feeds the command queue
module lrc_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  lrc_pkg::lrc_req_t            in_type,
	input  logic signed [COORD_BITS-1:0] in_x0,
	input  logic signed [COORD_BITS-1:0] in_y0,
	input  logic signed [COORD_BITS-1:0] in_x1,
	input  logic signed [COORD_BITS-1:0] in_y1,
	output logic                         out_valid,
	input  logic                         out_ready,
	output lrc_pkg::lrc_ctl_t            out_ctl,
	output logic signed [COORD_BITS-1:0] out_x0,
	output logic signed [COORD_BITS-1:0] out_y0,
	output logic [COORD_BITS:0]          out_major,
	output logic [COORD_BITS:0]          out_minor
);
	import lrc_pkg::*;

	localparam int CW = COORD_BITS + 1;

	logic                         v_s1, v_s2;
	logic                         en1, en2;
	lrc_req_t                     type_s1;
	logic signed [COORD_BITS-1:0] x0_s1, y0_s1, x0_s2, y0_s2;
	logic signed [CW-1:0]         dx_s1, dy_s1, dx_c, dy_c;
	logic [CW-1:0]                adx_c, ady_c, major_s2, minor_s2;
	lrc_ctl_t                     ctl_c, ctl_s2;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign dx_c = CW'(in_x1) - CW'(in_x0);
	assign dy_c = CW'(in_y1) - CW'(in_y0);

	// magnitude and direction; a zero delta counts as negative
	always_comb begin
		adx_c = dx_s1[CW-1] ? CW'(-dx_s1) : CW'(dx_s1);
		ady_c = dy_s1[CW-1] ? CW'(-dy_s1) : CW'(dy_s1);
		ctl_c.is_step    = (type_s1 == REQ_STEP);
		ctl_c.x_neg      = dx_s1[CW-1] || (dx_s1 == '0);
		ctl_c.y_neg      = dy_s1[CW-1] || (dy_s1 == '0);
		ctl_c.major_is_x = adx_c > ady_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			type_s1 <= in_type;
			x0_s1   <= in_x0;
			y0_s1   <= in_y0;
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
		end
		if (en2 && v_s1) begin
			ctl_s2   <= ctl_c;
			x0_s2    <= x0_s1;
			y0_s2    <= y0_s1;
			major_s2 <= ctl_c.major_is_x ? adx_c : ady_c;
			minor_s2 <= ctl_c.major_is_x ? ady_c : adx_c;
		end
	end

	assign out_valid = v_s2;
	assign out_ctl   = ctl_s2;
	assign out_x0    = x0_s2;
	assign out_y0    = y0_s2;
	assign out_major = major_s2;
	assign out_minor = minor_s2;

endmodule

@@ design/lrc_fifo.sv @@
// small command queue between front and back end
// depends on lrc_pkg for house conventions and on the assertion macro header
module lrc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	import lrc_pkg::*;
	`include "line_rasterizer_clipped_core_macros.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             push, pop, full, empty;

	assign full      = (count_q == NW'(DEPTH));
	assign empty     = (count_q == '0);
	assign in_ready  = !full;
	assign out_valid = !empty;
	assign push      = in_valid && !full;
	assign pop       = out_ready && !empty;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_data;
	end

	`LRC_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= NW'(DEPTH))
	`LRC_ASSERT_NEXT(a_push_counts, clk, arst_n, push && !pop, count_q == $past(count_q) + NW'(1))
	`LRC_ASSERT_IMPL(a_ptrs_match_empty, clk, arst_n, empty, wr_ptr_q == rd_ptr_q)

endmodule

@@ design/lrc_back.sv @@
// back end: walks a line a pixel per clock if unstalled, clips, forms address
// depends on lrc_pkg and the assertion macro header; fed by the command queue
module lrc_back #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lrc_pkg::lrc_cfg_t             cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lrc_pkg::lrc_ctl_t             in_ctl,
	input  logic signed [COORD_BITS-1:0]  in_x0,
	input  logic signed [COORD_BITS-1:0]  in_y0,
	input  logic [COORD_BITS:0]           in_major,
	input  logic [COORD_BITS:0]           in_minor,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS-1:0]  out_x,
	output logic signed [COORD_BITS-1:0]  out_y,
	output logic                          out_inside,
	output logic [lrc_pkg::ADDR_BITS-1:0] out_addr,
	output logic [7:0]                    out_blue,
	output logic [7:0]                    out_green,
	output logic [7:0]                    out_red,
	output logic                          out_last
);
	import lrc_pkg::*;
	`include "line_rasterizer_clipped_core_macros.svh"

	localparam int CW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 3;
	localparam int IW = (CW > DIM_BITS + 1) ? CW : DIM_BITS + 1;

	// line state
	logic signed [CW-1:0] cur_x_q, cur_y_q;
	logic [EW-1:0]        err_q, thr_q, inc_a_q, inc_b_q;
	logic [CW-1:0]        left_q;
	logic                 active_q, x_neg_q, y_neg_q, major_is_x_q;

	logic en1, en2, pop, start_fire, step_fire, last_c, ge_c;
	logic x_move_c, y_move_c, inside_c;
	logic signed [IW-1:0] x_ext_c, y_ext_c;
	logic [EW-1:0]        maj_e, min_e;
	logic [PROD_BITS-1:0] prod_c;
	logic [ADDR_BITS-1:0] addr_c;

	// pixel stage
	logic                 v_s1, inside_s1, last_s1;
	logic signed [CW-1:0] px_s1, py_s1;
	logic [DIM_BITS-1:0]  x_lo_s1, y_lo_s1;

	// output register
	logic                         out_valid_q, out_inside_q, out_last_q;
	logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
	logic [ADDR_BITS-1:0]         out_addr_q;
	logic [7:0]                   out_blue_q, out_green_q, out_red_q;

	assign en2        = !out_valid_q || out_ready;
	assign en1        = !v_s1 || en2;
	assign in_ready   = en1;
	assign pop        = in_valid && en1;
	assign start_fire = pop && !in_ctl.is_step;
	assign step_fire  = pop && in_ctl.is_step && active_q;

	assign last_c   = left_q <= CW'(1);
	assign ge_c     = err_q >= thr_q;
	assign x_move_c = major_is_x_q || ge_c;
	assign y_move_c = !major_is_x_q || ge_c;

	assign maj_e = EW'(in_major);
	assign min_e = EW'(in_minor);

	// clip test on the current position
	always_comb begin
		x_ext_c  = IW'(cur_x_q);
		y_ext_c  = IW'(cur_y_q);
		inside_c = !x_ext_c[IW-1] && !y_ext_c[IW-1] &&
		           ($unsigned(x_ext_c) < IW'(cfg.width)) &&
		           ($unsigned(y_ext_c) < IW'(cfg.height));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			err_q        <= '0;
			thr_q        <= '0;
			inc_a_q      <= '0;
			inc_b_q      <= '0;
			left_q       <= '0;
			active_q     <= 1'b0;
			x_neg_q      <= 1'b0;
			y_neg_q      <= 1'b0;
			major_is_x_q <= 1'b0;
			v_s1         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (start_fire) begin
				cur_x_q      <= CW'(in_x0);
				cur_y_q      <= CW'(in_y0);
				err_q        <= maj_e;
				thr_q        <= (maj_e << 1) + EW'(2) - (min_e << 1);
				inc_a_q      <= min_e << 1;
				inc_b_q      <= (min_e << 1) - (maj_e << 1);
				left_q       <= in_major + CW'(1);
				active_q     <= 1'b1;
				x_neg_q      <= in_ctl.x_neg;
				y_neg_q      <= in_ctl.y_neg;
				major_is_x_q <= in_ctl.major_is_x;
			end else if (step_fire) begin
				if (x_move_c) cur_x_q <= x_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
				if (y_move_c) cur_y_q <= y_neg_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
				err_q <= err_q + (ge_c ? inc_b_q : inc_a_q);
				if (last_c) begin
					left_q   <= '0;
					active_q <= 1'b0;
				end else begin
					left_q <= left_q - CW'(1);
				end
			end
			if (en1) v_s1 <= step_fire;
			if (en2) out_valid_q <= v_s1;
		end
	end

	assign prod_c = y_lo_s1 * cfg.stride;
	assign addr_c = prod_c[ADDR_BITS-1:0] + (ADDR_BITS'(x_lo_s1) << BPP_SHIFT);

	always_ff @(posedge clk) begin
		if (step_fire) begin
			px_s1     <= cur_x_q;
			py_s1     <= cur_y_q;
			inside_s1 <= inside_c;
			last_s1   <= last_c;
			x_lo_s1   <= x_ext_c[DIM_BITS-1:0];
			y_lo_s1   <= y_ext_c[DIM_BITS-1:0];
		end
		if (en2 && v_s1) begin
			out_x_q      <= px_s1[COORD_BITS-1:0];
			out_y_q      <= py_s1[COORD_BITS-1:0];
			out_inside_q <= inside_s1;
			out_last_q   <= last_s1;
			out_addr_q   <= inside_s1 ? addr_c : '0;
			out_blue_q   <= inside_s1 ? cfg.color[7:0] : 8'd0;
			out_green_q  <= inside_s1 ? cfg.color[15:8] : 8'd0;
			out_red_q    <= inside_s1 ? cfg.color[23:16] : 8'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_inside = out_inside_q;
	assign out_addr   = out_addr_q;
	assign out_blue   = out_blue_q;
	assign out_green  = out_green_q;
	assign out_red    = out_red_q;
	assign out_last   = out_last_q;

	`LRC_ASSERT_NEXT(a_last_ends_line, clk, arst_n, step_fire && last_c, !active_q)
	`LRC_ASSERT_IMPL(a_active_has_pixels, clk, arst_n, active_q, left_q != '0)
	`LRC_ASSERT_NEXT(a_idle_step_no_pixel, clk, arst_n, pop && in_ctl.is_step && !active_q, !v_s1)

endmodule

@@ design/line_rasterizer_clipped_core.sv @@
// top level of the clipped line rasterizer: register port, front end, queue, back end
// depends on lrc_pkg, lrc_front, lrc_fifo and lrc_back
//
// channel   side    transaction moves                      handshake
// s_*       in      one request: start a line or step it    s_tvalid & s_tready
// m_*       out     one pixel: coordinates, clip, address   m_tvalid & m_tready
// apb       config  one register write or read              psel & penable, pready high
//
// sustained rate is one pixel per clock with steps arriving and m_tready high; the
// back end pixel stepper makes one add and compare per pixel and a start request
// takes one queue slot and gives no pixel; an accepted step reaches m_tvalid through
// two front stages, the queue, the pixel stage and the address multiply into the
// output register; reset is asynchronous: it empties the pipeline and queue,
// drops any loaded line and returns the registers to their defaults
// a stall on m_tready backs up through the output register and pixel stage into the
// queue; the front end takes requests until the queue and both its stages are full
module line_rasterizer_clipped_core #(
	parameter int COORD_BITS  = 16,
	parameter int QUEUE_DEPTH = 4,
	localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_BITS + lrc_pkg::ADDR_BITS + lrc_pkg::COLOR_BITS + 7)
	                       / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// request stream
	input  logic             s_tvalid,
	output logic             s_tready,
	// start_x, start_y, end_x, end_y from bit 0 up
	input  logic [IN_W-1:0]  s_tdata,
	// req_type
	input  logic             s_tuser,
	// pixel stream
	output logic             m_tvalid,
	input  logic             m_tready,
	// pixel_x, pixel_y, byte_address, blue_byte, green_byte, red_byte from bit 0 up
	output logic [OUT_W-1:0] m_tdata,
	// in_bounds
	output logic             m_tuser,
	// last_pixel
	output logic             m_tlast,
	// register port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import lrc_pkg::*;

	localparam int CW = COORD_BITS + 1;
	localparam int QW = $bits(lrc_ctl_t) + 2 * COORD_BITS + 2 * CW;

	// configuration registers
	lrc_cfg_t cfg_q;
	logic     cfg_wr;
	lrc_reg_t reg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = lrc_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WIDTH_RESET;
			cfg_q.height <= HEIGHT_RESET;
			cfg_q.stride <= STRIDE_RESET;
			cfg_q.color  <= COLOR_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_IMAGE_WIDTH:  cfg_q.width  <= pwdata[DIM_BITS-1:0];
				REG_IMAGE_HEIGHT: cfg_q.height <= pwdata[DIM_BITS-1:0];
				REG_ROW_STRIDE:   cfg_q.stride <= pwdata[STRIDE_BITS-1:0];
				REG_DRAW_COLOR:   cfg_q.color  <= pwdata[COLOR_BITS-1:0];
				default:          cfg_q        <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IMAGE_WIDTH:  prdata = 32'(cfg_q.width);
			REG_IMAGE_HEIGHT: prdata = 32'(cfg_q.height);
			REG_ROW_STRIDE:   prdata = 32'(cfg_q.stride);
			REG_DRAW_COLOR:   prdata = 32'(cfg_q.color);
			default:          prdata = '0;
		endcase
	end

	// request fields
	logic signed [COORD_BITS-1:0] req_x0, req_y0, req_x1, req_y1;

	assign req_x0 = s_tdata[COORD_BITS-1:0];
	assign req_y0 = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign req_x1 = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign req_y1 = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

	// front end to queue
	logic                         f_valid, f_ready;
	lrc_ctl_t                     f_ctl;
	logic signed [COORD_BITS-1:0] f_x0, f_y0;
	logic [CW-1:0]                f_major, f_minor;

	lrc_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_type   (lrc_req_t'(s_tuser)),
		.in_x0     (req_x0),
		.in_y0     (req_y0),
		.in_x1     (req_x1),
		.in_y1     (req_y1),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_ctl   (f_ctl),
		.out_x0    (f_x0),
		.out_y0    (f_y0),
		.out_major (f_major),
		.out_minor (f_minor)
	);

	// command queue, one entry per request
	logic          q_valid, q_ready;
	logic [QW-1:0] q_wdata, q_rdata;
	lrc_ctl_t      q_ctl;
	logic signed [COORD_BITS-1:0] q_x0, q_y0;
	logic [CW-1:0] q_major, q_minor;

	assign q_wdata = {f_ctl, f_x0, f_y0, f_major, f_minor};
	assign {q_ctl, q_x0, q_y0, q_major, q_minor} = q_rdata;

	lrc_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (q_wdata),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_rdata)
	);

	// back end to pixel stream
	logic signed [COORD_BITS-1:0] pix_x, pix_y;
	logic [ADDR_BITS-1:0]         pix_addr;
	logic [7:0]                   pix_blue, pix_green, pix_red;

	lrc_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (q_valid),
		.in_ready   (q_ready),
		.in_ctl     (q_ctl),
		.in_x0      (q_x0),
		.in_y0      (q_y0),
		.in_major   (q_major),
		.in_minor   (q_minor),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_x      (pix_x),
		.out_y      (pix_y),
		.out_inside (m_tuser),
		.out_addr   (pix_addr),
		.out_blue   (pix_blue),
		.out_green  (pix_green),
		.out_red    (pix_red),
		.out_last   (m_tlast)
	);

	// pack pixel fields from bit 0 up, zero fill to whole bytes
	assign m_tdata = OUT_W'({pix_red, pix_green, pix_blue, pix_addr, pix_y, pix_x});

endmodule
